// File: hdl/serial_command_line_editor_macros.svh
// Assertion macros used by the checker of the command line editor.
`ifndef SERIAL_COMMAND_LINE_EDITOR_MACROS_SVH
`define SERIAL_COMMAND_LINE_EDITOR_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SCLE_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SCLE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/scle_pkg.sv
package scle_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_CHAR  = 3'd1;
    localparam logic [2:0] CMD_ERASE = 3'd2;
    localparam logic [2:0] CMD_SPACE = 3'd3;
    localparam logic [2:0] CMD_ENDL  = 3'd4;
    localparam logic [2:0] CMD_SLASH = 3'd5;
    localparam logic [2:0] CMD_ABORT = 3'd6;

    localparam logic [2:0] KIND_ECHO    = 3'd0;
    localparam logic [2:0] KIND_ERASE   = 3'd1;
    localparam logic [2:0] KIND_NEWLINE = 3'd2;
    localparam logic [2:0] KIND_RESET   = 3'd3;
    localparam logic [2:0] KIND_TOKEN   = 3'd4;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_OPER  = 2'd1;
    localparam logic [1:0] MODE_PARAM = 2'd2;

    localparam logic [7:0] KEY_CTRL_C = 8'h03;
    localparam logic [7:0] KEY_BS     = 8'h08;
    localparam logic [7:0] KEY_TAB    = 8'h09;
    localparam logic [7:0] KEY_LF     = 8'h0a;
    localparam logic [7:0] KEY_CR     = 8'h0d;
    localparam logic [7:0] KEY_ESC    = 8'h1b;
    localparam logic [7:0] KEY_SPACE  = 8'h20;
    localparam logic [7:0] KEY_SLASH  = 8'h2f;
    localparam logic [7:0] KEY_DEL    = 8'h7f;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] ch;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  echo;
        logic [2:0]  index;
        logic [3:0]  length;
        logic [63:0] text;
        logic        last;
    } res_t;

endpackage

// File: hdl/scle_front.sv
module scle_front
    import scle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] rx_byte,
    output logic       full,
    output logic       cmd_valid,
    output cmd_t       cmd,
    input  logic       cmd_take
);

    cmd_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    cmd_t              word_in;
    logic              wr_en;

    function automatic logic [2:0] classify(input logic [7:0] b);
        logic [2:0] op;
        op = CMD_NONE;
        priority if (b == KEY_CTRL_C || b == KEY_ESC)
            op = CMD_ABORT;
        else if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5a) ||
                 (b >= 8'h61 && b <= 8'h7a) || b == 8'h5f || b == 8'h2e ||
                 b == 8'h2d)
            op = CMD_CHAR;
        else if (b == KEY_BS || b == KEY_DEL)
            op = CMD_ERASE;
        else if (b == KEY_SPACE)
            op = CMD_SPACE;
        else if (b == KEY_LF || b == KEY_TAB)
            op = CMD_ENDL;
        else if (b == KEY_SLASH)
            op = CMD_SLASH;
        else
            op = CMD_NONE;
        return op;
    endfunction

    // Bytes that can never cause a result are accepted and dropped here.
    always_comb
    begin
        word_in.op  = classify(rx_byte);
        word_in.ch  = rx_byte;
        full        = (cnt_reg == QCNT_W'(QDEPTH));
        wr_en       = push && !full && (word_in.op != CMD_NONE);
        cmd_valid   = (cnt_reg != '0);
        cmd         = q_reg[rd_ptr_reg];
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = cmd_take ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(wr_en) - QCNT_W'(cmd_take);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_ptr_reg] <= word_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: hdl/scle_back.sv
module scle_back
    import scle_pkg::*;
#(
    parameter int OPERATOR_LEN = 8,
    parameter int PARAM_LEN    = 8,
    parameter int PARAM_SLOTS  = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_take,
    input  logic pop,
    output logic res_valid,
    output res_t res
);

    localparam int CNT_W = $clog2(PARAM_SLOTS + 1);
    localparam int IDX_W = (PARAM_SLOTS > 1) ? $clog2(PARAM_SLOTS) : 1;
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(PARAM_SLOTS);
    localparam logic [3:0] OPLEN_C = 4'(OPERATOR_LEN);
    localparam logic [3:0] PLEN_C  = 4'(PARAM_LEN);
    localparam logic ST_CMD = 1'b0;
    localparam logic ST_FIN = 1'b1;

    logic             state_reg, state_next;
    logic [1:0]       mode_reg, mode_next;
    logic [63:0]      optext_reg, optext_next;
    logic [3:0]       oplen_reg, oplen_next;
    logic [63:0]      ptext_reg [PARAM_SLOTS];
    logic [63:0]      ptext_next [PARAM_SLOTS];
    logic [3:0]       plen_reg [PARAM_SLOTS];
    logic [3:0]       plen_next [PARAM_SLOTS];
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] tok_reg, tok_next;
    logic             out_valid_reg, out_valid_next;
    res_t             out_reg;
    res_t             res_new;
    logic             load;
    logic             out_free;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] new_idx;
    logic [3:0]       cur_len;
    logic [63:0]      cur_text;

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        optext_next = optext_reg;
        oplen_next  = oplen_reg;
        ptext_next  = ptext_reg;
        plen_next   = plen_reg;
        count_next  = count_reg;
        tok_next    = tok_reg;
        cmd_take    = 1'b0;
        load        = 1'b0;
        res_new     = '0;
        out_free    = !out_valid_reg || pop;
        rd_idx      = (state_reg == ST_FIN) ? IDX_W'(tok_reg - 1'b1)
                                            : IDX_W'(count_reg - 1'b1);
        new_idx     = IDX_W'(count_reg);
        cur_len     = plen_reg[rd_idx];
        cur_text    = ptext_reg[rd_idx];

        unique case (state_reg)
            ST_CMD:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_take = 1'b1;
                    unique case (cmd.op)
                        CMD_ABORT:
                        begin
                            if (mode_reg != MODE_IDLE)
                            begin
                                mode_next    = MODE_IDLE;
                                oplen_next   = '0;
                                count_next   = '0;
                                load         = 1'b1;
                                res_new.kind = KIND_RESET;
                                res_new.last = 1'b1;
                            end
                        end
                        CMD_CHAR:
                        begin
                            if (mode_reg == MODE_OPER && oplen_reg < OPLEN_C)
                            begin
                                optext_next[8*oplen_reg[2:0] +: 8] = cmd.ch;
                                oplen_next   = oplen_reg + 1'b1;
                                load         = 1'b1;
                                res_new.kind = KIND_ECHO;
                                res_new.echo = cmd.ch;
                                res_new.last = 1'b1;
                            end
                            else if (mode_reg == MODE_PARAM && cur_len < PLEN_C)
                            begin
                                ptext_next[rd_idx][8*cur_len[2:0] +: 8] = cmd.ch;
                                plen_next[rd_idx] = cur_len + 1'b1;
                                load         = 1'b1;
                                res_new.kind = KIND_ECHO;
                                res_new.echo = cmd.ch;
                                res_new.last = 1'b1;
                            end
                        end
                        CMD_ERASE:
                        begin
                            if (mode_reg == MODE_OPER)
                            begin
                                load         = 1'b1;
                                res_new.kind = KIND_ERASE;
                                res_new.last = 1'b1;
                                if (oplen_reg != '0)
                                begin
                                    optext_next[8*(3'(oplen_reg - 1'b1)) +: 8] = 8'h00;
                                    oplen_next = oplen_reg - 1'b1;
                                end
                                else
                                begin
                                    mode_next  = MODE_IDLE;
                                    count_next = '0;
                                end
                            end
                            else if (mode_reg == MODE_PARAM)
                            begin
                                load         = 1'b1;
                                res_new.kind = KIND_ERASE;
                                res_new.last = 1'b1;
                                if (cur_len != '0)
                                begin
                                    ptext_next[rd_idx][8*(3'(cur_len - 1'b1)) +: 8] = 8'h00;
                                    plen_next[rd_idx] = cur_len - 1'b1;
                                end
                                else
                                begin
                                    count_next = count_reg - 1'b1;
                                    if (count_reg == CNT_W'(1))
                                    begin
                                        mode_next = MODE_OPER;
                                    end
                                end
                            end
                        end
                        CMD_SPACE:
                        begin
                            if (mode_reg == MODE_OPER && oplen_reg != '0)
                            begin
                                mode_next     = MODE_PARAM;
                                count_next    = CNT_W'(1);
                                ptext_next[0] = '0;
                                plen_next[0]  = '0;
                                load          = 1'b1;
                                res_new.kind  = KIND_ECHO;
                                res_new.echo  = KEY_SPACE;
                                res_new.last  = 1'b1;
                            end
                            else if (mode_reg == MODE_PARAM && count_reg < SLOTS_C)
                            begin
                                count_next          = count_reg + 1'b1;
                                ptext_next[new_idx] = '0;
                                plen_next[new_idx]  = '0;
                                load                = 1'b1;
                                res_new.kind        = KIND_ECHO;
                                res_new.echo        = KEY_SPACE;
                                res_new.last        = 1'b1;
                            end
                        end
                        CMD_ENDL:
                        begin
                            if ((mode_reg == MODE_OPER && oplen_reg != '0) ||
                                mode_reg == MODE_PARAM)
                            begin
                                load         = 1'b1;
                                res_new.kind = KIND_NEWLINE;
                                state_next   = ST_FIN;
                                tok_next     = '0;
                            end
                        end
                        CMD_SLASH:
                        begin
                            if (mode_reg == MODE_IDLE)
                            begin
                                mode_next    = MODE_OPER;
                                optext_next  = '0;
                                oplen_next   = '0;
                                count_next   = '0;
                                load         = 1'b1;
                                res_new.kind = KIND_ECHO;
                                res_new.echo = KEY_SLASH;
                                res_new.last = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    load          = 1'b1;
                    res_new.kind  = KIND_TOKEN;
                    res_new.index = 3'(tok_reg);
                    res_new.last  = (tok_reg == count_reg);
                    if (tok_reg == '0)
                    begin
                        res_new.length = oplen_reg;
                        res_new.text   = optext_reg;
                    end
                    else
                    begin
                        res_new.length = cur_len;
                        res_new.text   = cur_text;
                    end
                    if (tok_reg == count_reg)
                    begin
                        state_next = ST_CMD;
                        mode_next  = MODE_IDLE;
                        oplen_next = '0;
                        count_next = '0;
                    end
                    else
                    begin
                        tok_next = tok_reg + 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (load)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_ff @(posedge clk)
    begin
        optext_reg <= optext_next;
        ptext_reg  <= ptext_next;
        if (load)
        begin
            out_reg <= res_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CMD;
            mode_reg      <= MODE_IDLE;
            oplen_reg     <= '0;
            count_reg     <= '0;
            tok_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < PARAM_SLOTS; i++)
            begin
                plen_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            oplen_reg     <= oplen_next;
            count_reg     <= count_next;
            tok_reg       <= tok_next;
            out_valid_reg <= out_valid_next;
            plen_reg      <= plen_next;
        end
    end

endmodule

// File: hdl/serial_command_line_editor.sv
// Serial command line editor. Each pushed word is one received byte; the
// results queue out words for a terminal: echoed characters, erase, newline,
// reset notices and, at a line end, the operator and each parameter packed
// with its first character in the low byte. A byte is taken in every cycle
// while the four-word input queue has room. The back end executes one queued
// byte per cycle; a line end occupies it until its newline and tokens are out,
// one result per cycle, and it waits whenever the single result register is
// full and not popped.
module serial_command_line_editor
    import scle_pkg::*;
#(
    parameter int OPERATOR_LEN = 8,
    parameter int PARAM_LEN    = 8,
    parameter int PARAM_SLOTS  = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic [7:0]  rx_byte,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  event_kind,
    output logic [7:0]  echo_char,
    output logic [2:0]  token_index,
    output logic [3:0]  token_length,
    output logic [63:0] token_text,
    output logic        last
);

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_take;
    logic res_valid;
    res_t res;

    scle_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .rx_byte   (rx_byte),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    scle_back #(
        .OPERATOR_LEN (OPERATOR_LEN),
        .PARAM_LEN    (PARAM_LEN),
        .PARAM_SLOTS  (PARAM_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .pop       (pop),
        .res_valid (res_valid),
        .res       (res)
    );

    assign empty        = !res_valid;
    assign event_kind   = res.kind;
    assign echo_char    = res.echo;
    assign token_index  = res.index;
    assign token_length = res.length;
    assign token_text   = res.text;
    assign last         = res.last;

endmodule

// File: hdl/scle_checker.sv
`include "serial_command_line_editor_macros.svh"

module scle_checker
    import scle_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  event_kind,
    input logic [7:0]  echo_char,
    input logic [2:0]  token_index,
    input logic [3:0]  token_length,
    input logic [63:0] token_text,
    input logic        last
);

    logic        shown;
    logic        is_token;
    logic        tok_zero;
    logic        oper_tok;
    logic        nl_taken;
    logic [66:0] held_view;

    assign shown     = !empty;
    assign is_token  = (event_kind == KIND_TOKEN);
    assign tok_zero  = (token_length == 4'd0) && (token_text == 64'd0) &&
                       (token_index == 3'd0);
    assign oper_tok  = is_token && (token_index == 3'd0);
    assign nl_taken  = shown && pop && (event_kind == KIND_NEWLINE);
    assign held_view = {event_kind, token_text};

    // A waiting word stays until it is popped.
    `SCLE_ASSERT_NXT(a_hold, shown && !pop, shown && $stable(held_view), "waiting word changed")
    // Only token words carry text and length.
    `SCLE_ASSERT(a_tok_only, shown && !is_token, tok_zero, "token fields set on a non-token word")
    // Token words never carry an echo character.
    `SCLE_ASSERT(a_tok_echo, shown && is_token, echo_char == 8'd0, "echo on a token word")
    // A reset notice is always the only result of its byte.
    `SCLE_ASSERT(a_reset_last, shown && event_kind == KIND_RESET, last, "reset notice not last")
    // A newline is always followed by the operator token.
    `SCLE_ASSERT_NXT(a_nl_next, nl_taken, empty || oper_tok, "no operator after newline")

endmodule

bind serial_command_line_editor scle_checker u_scle_checker (.*);

// File: verif/tb_top.sv
module tb_top;

    import scle_pkg::*;

    localparam int TOKEN_CHARS  = 8;
    localparam int PARAM_SLOTS  = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_BYTES  = 50;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic [7:0]  rx_byte;
    logic        full;
    logic        empty;
    logic        pop;
    logic [2:0]  event_kind;
    logic [7:0]  echo_char;
    logic [2:0]  token_index;
    logic [3:0]  token_length;
    logic [63:0] token_text;
    logic        last;

    int send_idle_pct;
    int recv_idle_pct;
    int mismatch_count;
    int sent_bytes;
    int cycle_count;

    res_t expected_words[$];
    res_t oldest_word;

    logic [1:0] edit_mode;
    logic [7:0] oper_text [TOKEN_CHARS];
    int         oper_len;
    logic [7:0] param_text [PARAM_SLOTS][TOKEN_CHARS];
    int         param_fill [PARAM_SLOTS];
    int         param_open;

    serial_command_line_editor #(
        .OPERATOR_LEN (TOKEN_CHARS),
        .PARAM_LEN    (TOKEN_CHARS),
        .PARAM_SLOTS  (PARAM_SLOTS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .rx_byte      (rx_byte),
        .full         (full),
        .empty        (empty),
        .pop          (pop),
        .event_kind   (event_kind),
        .echo_char    (echo_char),
        .token_index  (token_index),
        .token_length (token_length),
        .token_text   (token_text),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL serial_command_line_editor");
            $finish;
        end
    end

    function automatic bit is_token_char(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
               (c >= "a" && c <= "z") || c == "_" || c == "." || c == "-";
    endfunction

    task automatic add_word(logic [2:0] kind, logic [7:0] ch, logic [2:0] idx,
                            logic [3:0] len, logic [63:0] text);
        res_t w;
        w.kind   = kind;
        w.echo   = ch;
        w.index  = idx;
        w.length = len;
        w.text   = text;
        w.last   = 1'b0;
        expected_words.push_back(w);
    endtask

    task automatic clear_edit_line();
        edit_mode  = MODE_IDLE;
        oper_len   = 0;
        param_open = 0;
        foreach (oper_text[i])
            oper_text[i] = 8'h00;
        foreach (param_text[k, i])
            param_text[k][i] = 8'h00;
        foreach (param_fill[k])
            param_fill[k] = 0;
    endtask

    task automatic emit_command_tokens();
        logic [63:0] text;
        text = '0;
        add_word(KIND_NEWLINE, 8'h00, 3'd0, 4'd0, 64'd0);
        for (int i = 0; i < oper_len; i++)
            text[8*i +: 8] = oper_text[i];
        add_word(KIND_TOKEN, 8'h00, 3'd0, oper_len[3:0], text);
        for (int k = 0; k < param_open; k++)
        begin
            text = '0;
            for (int i = 0; i < param_fill[k]; i++)
                text[8*i +: 8] = param_text[k][i];
            add_word(KIND_TOKEN, 8'h00, 3'(k + 1), param_fill[k][3:0], text);
        end
        clear_edit_line();
    endtask

    task automatic predict_line_editor(logic [7:0] b);
        int  start_size;
        int  cur;
        bit  erase;
        bit  endl;
        start_size = expected_words.size();
        erase = (b == KEY_BS || b == KEY_DEL);
        endl  = (b == KEY_LF || b == KEY_TAB);
        cur   = (param_open >= 1) ? param_open - 1 : 0;
        if ((b == KEY_CTRL_C || b == KEY_ESC) && edit_mode != MODE_IDLE)
        begin
            clear_edit_line();
            add_word(KIND_RESET, 8'h00, 3'd0, 4'd0, 64'd0);
        end
        else if (b == KEY_CR)
        begin
        end
        else if (edit_mode == MODE_OPER)
        begin
            if (is_token_char(b))
            begin
                if (oper_len < TOKEN_CHARS)
                begin
                    oper_text[oper_len] = b;
                    oper_len++;
                    add_word(KIND_ECHO, b, 3'd0, 4'd0, 64'd0);
                end
            end
            else if (erase)
            begin
                add_word(KIND_ERASE, 8'h00, 3'd0, 4'd0, 64'd0);
                if (oper_len > 0)
                begin
                    oper_len--;
                    oper_text[oper_len] = 8'h00;
                end
                else
                    clear_edit_line();
            end
            else if (b == KEY_SPACE)
            begin
                if (oper_len > 0)
                begin
                    edit_mode  = MODE_PARAM;
                    param_open = 1;
                    add_word(KIND_ECHO, KEY_SPACE, 3'd0, 4'd0, 64'd0);
                end
            end
            else if (endl && oper_len > 0)
                emit_command_tokens();
        end
        else if (edit_mode == MODE_PARAM)
        begin
            if (is_token_char(b))
            begin
                if (param_fill[cur] < TOKEN_CHARS)
                begin
                    param_text[cur][param_fill[cur]] = b;
                    param_fill[cur]++;
                    add_word(KIND_ECHO, b, 3'd0, 4'd0, 64'd0);
                end
            end
            else if (erase)
            begin
                add_word(KIND_ERASE, 8'h00, 3'd0, 4'd0, 64'd0);
                if (param_fill[cur] > 0)
                begin
                    param_fill[cur]--;
                    param_text[cur][param_fill[cur]] = 8'h00;
                end
                else
                begin
                    param_open = cur;
                    if (param_open == 0)
                        edit_mode = MODE_OPER;
                end
            end
            else if (b == KEY_SPACE)
            begin
                if (param_open < PARAM_SLOTS)
                begin
                    param_open++;
                    add_word(KIND_ECHO, KEY_SPACE, 3'd0, 4'd0, 64'd0);
                end
            end
            else if (endl)
                emit_command_tokens();
        end
        else if (b == KEY_SLASH)
        begin
            edit_mode = MODE_OPER;
            add_word(KIND_ECHO, KEY_SLASH, 3'd0, 4'd0, 64'd0);
        end
        if (expected_words.size() > start_size)
            expected_words[expected_words.size() - 1].last = 1'b1;
    endtask

    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sent_bytes++;
        predict_line_editor(b);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v,
                     act_v);
            mismatch_count++;
        end
    endtask

    // A word is taken at an edge where pop is high and empty is low.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual kind %0d",
                             $time, event_kind);
                    mismatch_count++;
                end
                else
                begin
                    oldest_word = expected_words.pop_front();
                    check_field("event_kind", 64'(oldest_word.kind), 64'(event_kind));
                    check_field("echo_char", 64'(oldest_word.echo), 64'(echo_char));
                    check_field("token_index", 64'(oldest_word.index), 64'(token_index));
                    check_field("token_length", 64'(oldest_word.length),
                                64'(token_length));
                    check_field("token_text", oldest_word.text, token_text);
                    check_field("last", 64'(oldest_word.last), 64'(last));
                end
            end
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic logic [7:0] pick_token_char();
        int r;
        r = $urandom_range(0, 64);
        if (r < 10)
            return 8'("0" + r);
        else if (r < 36)
            return 8'("A" + r - 10);
        else if (r < 62)
            return 8'("a" + r - 36);
        else if (r == 62)
            return "_";
        else if (r == 63)
            return ".";
        return "-";
    endfunction

    task automatic send_line_char();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            send_byte($urandom_range(0, 1) ? KEY_BS : KEY_DEL);
        else if (pick == 1)
            send_byte(8'($urandom_range(0, 255)));
        else
            send_byte(pick_token_char());
    endtask

    task automatic send_random_line();
        int n_chars;
        int n_params;
        int pick;
        if ($urandom_range(0, 9) == 0)
            send_byte(8'($urandom_range(0, 255)));
        send_byte(KEY_SLASH);
        n_chars = $urandom_range(0, 9);
        for (int i = 0; i < n_chars; i++)
            send_line_char();
        n_params = $urandom_range(0, 5);
        for (int k = 0; k < n_params; k++)
        begin
            send_byte(KEY_SPACE);
            n_chars = $urandom_range(0, 9);
            for (int i = 0; i < n_chars; i++)
                send_line_char();
        end
        pick = $urandom_range(0, 19);
        if (pick < 12)
            send_byte($urandom_range(0, 1) ? KEY_LF : KEY_TAB);
        else if (pick < 14)
            send_byte($urandom_range(0, 1) ? KEY_ESC : KEY_CTRL_C);
        else if (pick < 16)
        begin
            n_chars = $urandom_range(1, 12);
            for (int i = 0; i < n_chars; i++)
                send_byte($urandom_range(0, 1) ? KEY_BS : KEY_DEL);
            send_byte(KEY_LF);
        end
        else if (pick == 16)
        begin
            send_byte(KEY_CR);
            send_byte(KEY_LF);
        end
    endtask

    task automatic test_idle_line();
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(KEY_ESC);
        send_byte(KEY_CTRL_C);
        send_text("a");
    endtask

    task automatic test_operator_edits();
        send_text("/ ");
        send_byte(KEY_LF);
        send_byte(KEY_BS);
        send_text("/0");
        send_byte(KEY_DEL);
        send_byte(KEY_CR);
        send_byte(KEY_ESC);
    endtask

    task automatic test_full_line();
        send_text("/z9_.-AZaq");
        send_byte(KEY_SPACE);
        send_byte(KEY_DEL);
        send_text("     ");
        send_byte(KEY_BS);
        send_byte(KEY_TAB);
    endtask

    task automatic test_random_lines(int idle_send, int idle_recv);
        int goal;
        send_idle_pct = idle_send;
        recv_idle_pct = idle_recv;
        goal = sent_bytes + PHASE_BYTES;
        while (sent_bytes < goal)
            send_random_line();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        push           = 1'b0;
        rx_byte        = 8'h00;
        pop            = 1'b0;
        send_idle_pct  = 11;
        recv_idle_pct  = 47;
        mismatch_count = 0;
        sent_bytes     = 0;
        cycle_count    = 0;
        clear_edit_line();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_line();
        test_operator_edits();
        test_full_line();
        test_random_lines(11, 47);
        test_random_lines(47, 11);
        test_random_lines(0, 0);

        push <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS serial_command_line_editor");
        else
            $display("FAIL serial_command_line_editor");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/scle_pkg.sv
hdl/scle_front.sv
hdl/scle_back.sv
hdl/serial_command_line_editor.sv
hdl/scle_checker.sv
verif/tb_top.sv
